// ===== hdl/perlin_octave_noise_assert.svh =====
// Assertion macros for the octave noise engine.
`ifndef PERLIN_OCTAVE_NOISE_ASSERT_SVH
`define PERLIN_OCTAVE_NOISE_ASSERT_SVH
// Check that cons holds in the same cycle as ante.
`define PON_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define PON_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hdl/pon_pkg.sv =====
// Package with shared types and constants of the octave noise engine.
package pon_pkg;
	localparam logic       FUNC_WRITE = 1'b0;
	localparam logic       FUNC_EVAL  = 1'b1;
	localparam logic [1:0] CFG_DIM    = 2'd0;
	localparam logic [1:0] CFG_OCT    = 2'd1;
	localparam logic [1:0] CFG_PERS   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_OCT, ST_FADE0, ST_FADE1, ST_FADE2, ST_FADE3, ST_FADE4,
		ST_RDA, ST_RDD, ST_GRAD, ST_LERP0, ST_LERP1,
		ST_ACC0, ST_ACC1, ST_ACC2, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] axis;
		logic [2:0] ia;
		logic [2:0] ib;
	} lerp_step_t;
endpackage

// ===== hdl/pon_if.sv =====
// Channel interfaces: evaluate/write items, results and configuration writes.
interface pon_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  entry_index;
	logic [7:0]  entry_value;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;
	modport source (output valid, func, entry_index, entry_value, coord_x, coord_y,
		coord_z, input ready);
	modport sink (input valid, func, entry_index, entry_value, coord_x, coord_y,
		coord_z, output ready);
endinterface

interface pon_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] noise_value;
	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

interface pon_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/perlin_octave_noise.sv =====
// Top level of the octave noise engine: sequencer, permutation memory and datapath.
// Channels: req takes items (func 0 writes one permutation entry, func 1
// evaluates noise at coord_x/y/z), rsp returns one noise_value per evaluate
// item, cfg writes dimension_mode, octave_count and persistence; the user must
// write them only while the block is idle, which the block itself does not enforce; cfg is always ready.
// An item is taken only while the sequencer is idle. A write item finishes
// in the cycle it is taken and returns nothing.
// An evaluate item runs octave by octave through one shared 34x22 multiplier
// and the single-port permutation memory (each table read is an ST_RDA and an
// ST_RDD state), then the division makes one quotient bit per cycle, and the
// result is loaded into the output register from ST_DONE.
// The result sits in an output register; the next item is taken while it
// waits. If rsp stalls and a second result is ready, the sequencer holds
// it until the output register frees.
// Reset clears the control state, the configuration registers and the output valid flag; the
// permutation memory is not cleared and must be written before use.
`include "perlin_octave_noise_assert.svh"
module perlin_octave_noise #(
	parameter int TABLE_SIZE      = 256,
	parameter int MAX_OCTAVES     = 8,
	parameter int COORD_FRAC_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	pon_in_if.sink    req,
	pon_out_if.source rsp,
	pon_cfg_if.sink   cfg
);
	import pon_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);
	localparam int AMP_W   = 16 + MAX_OCTAVES;
	localparam int TOT_W   = AMP_W + 22;
	localparam int DW      = AMP_W + 2;
	localparam int DC_W    = $clog2(TOT_W + 1);
	localparam int ONE     = 65536;
	localparam int DOWN_SH = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
	localparam int UP_SH   = (COORD_FRAC_BITS < 16) ? 16 - COORD_FRAC_BITS : 0;
	localparam logic [31:0] FRAC_MASK = 32'((64'd1 << COORD_FRAC_BITS) - 64'd1);

	state_t state_q, state_d;

	logic              dim_q;
	logic [3:0]        oct_cfg_q;
	logic [15:0]       pers_q;

	logic [31:0]       cx_q, cy_q, cz_q;
	logic [CNT_W-1:0]  oct_i_q, n_oct;
	logic [IDX_W-1:0]  gx_q, gy_q, gz_q;
	logic signed [16:0] fr_q [0:2];
	logic signed [17:0] fd_q [0:2];
	logic signed [17:0] t3_q;
	logic [1:0]        ax_q;
	logic [3:0]        k_q;
	logic [7:0]        hreg_q [0:13];
	logic signed [20:0] gr_q [0:7];
	logic [2:0]        ls_q;
	logic [AMP_W-1:0]  amp_q;
	logic [AMP_W:0]    amp_sum_q;
	logic signed [TOT_W-1:0] total_q;

	logic [TOT_W-1:0]  quo_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     dvs_q;
	logic              neg_q;
	logic [DC_W-1:0]   dcnt_q;

	logic [7:0]        mem [0:TABLE_SIZE-1];
	logic [7:0]        rd_q;
	logic [IDX_W-1:0]  rd_addr;

	logic signed [33:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [55:0] prod_s1;

	logic              rsp_valid_q;
	logic signed [15:0] rsp_data_q;

	logic              in_acc, last_ax, last_rd, last_ls, last_oct, out_load;
	lerp_step_t        lstep;
	logic signed [16:0] ft;
	logic [DW:0]       rem_sh;
	logic signed [15:0] sat_val;

	function automatic lerp_step_t lerp_prog(input logic [2:0] s);
		lerp_step_t r;
		unique case (s)
			3'd0: r = '{2'd0, 3'd0, 3'd4};
			3'd1: r = '{2'd0, 3'd2, 3'd6};
			3'd2: r = '{2'd0, 3'd1, 3'd5};
			3'd3: r = '{2'd0, 3'd3, 3'd7};
			3'd4: r = '{2'd1, 3'd0, 3'd2};
			3'd5: r = '{2'd1, 3'd1, 3'd3};
			default: r = '{2'd2, 3'd0, 3'd1};
		endcase
		return r;
	endfunction

	function automatic logic signed [20:0] slope2(input logic [7:0] h,
			input logic signed [17:0] px, input logic signed [17:0] py);
		logic signed [20:0] x, y, r;
		x = 21'(px);
		y = 21'(py);
		unique case (h[2:0])
			3'd0: r = x + y;
			3'd1: r = x - y;
			3'd2: r = y - x;
			3'd3: r = -x - y;
			3'd4: r = x;
			3'd5: r = -x;
			3'd6: r = y;
			default: r = -y;
		endcase
		return r;
	endfunction

	function automatic logic signed [20:0] slope3(input logic [7:0] h,
			input logic signed [17:0] px, input logic signed [17:0] py,
			input logic signed [17:0] pz);
		logic [3:0] k;
		logic signed [20:0] s, r;
		k = h[3:0];
		s = (k < 4'd8) ? 21'(px) : 21'(py);
		r = (k < 4'd4) ? 21'(py) : ((k == 4'd12 || k == 4'd14) ? 21'(px) : 21'(pz));
		return (k[0] ? -s : s) + (k[1] ? -r : r);
	endfunction

	assign in_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.noise_value = rsp_data_q;

	always_comb begin
		if (oct_cfg_q == 4'd0)
			n_oct = CNT_W'(1);
		else if (int'(oct_cfg_q) > MAX_OCTAVES)
			n_oct = CNT_W'(MAX_OCTAVES);
		else
			n_oct = CNT_W'(oct_cfg_q);
	end

	assign ft       = fr_q[ax_q];
	assign last_ax  = dim_q ? (ax_q == 2'd2) : (ax_q == 2'd1);
	assign last_rd  = dim_q ? (k_q == 4'd13) : (k_q == 4'd5);
	assign last_ls  = dim_q ? (ls_q == 3'd6) : (ls_q == 3'd4);
	assign last_oct = (oct_i_q == n_oct - CNT_W'(1));
	assign lstep    = lerp_prog(ls_q);
	assign out_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign rem_sh   = {rem_q, quo_q[TOT_W-1]};

	always_comb begin
		if (neg_q)
			sat_val = (quo_q > TOT_W'(32768)) ? -16'sd32768 : 16'(-quo_q);
		else
			sat_val = (quo_q > TOT_W'(32767)) ? 16'sd32767 : 16'(quo_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && req.func == FUNC_EVAL) state_d = ST_OCT;
			ST_OCT:   state_d = ST_FADE0;
			ST_FADE0: state_d = ST_FADE1;
			ST_FADE1: state_d = ST_FADE2;
			ST_FADE2: state_d = ST_FADE3;
			ST_FADE3: state_d = ST_FADE4;
			ST_FADE4: state_d = last_ax ? ST_RDA : ST_FADE0;
			ST_RDA:   state_d = ST_RDD;
			ST_RDD:   state_d = last_rd ? ST_GRAD : ST_RDA;
			ST_GRAD:  state_d = ST_LERP0;
			ST_LERP0: state_d = ST_LERP1;
			ST_LERP1: state_d = last_ls ? ST_ACC0 : ST_LERP0;
			ST_ACC0:  state_d = ST_ACC1;
			ST_ACC1:  state_d = ST_ACC2;
			ST_ACC2:  state_d = last_oct ? ST_DIV : ST_OCT;
			ST_DIV:   if (dcnt_q == DC_W'(1)) state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		logic [IDX_W-1:0] base;
		logic [IDX_W-1:0] g;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_FADE0: begin
				mul_a = 34'(ft);
				mul_b = 22'(ft);
			end
			ST_FADE1: begin
				mul_a = 34'(prod_s1 >>> 16);
				mul_b = 22'(ft);
			end
			ST_FADE2: begin
				mul_a = 34'(ft);
				mul_b = 22'(ft * 6 - 15 * ONE);
			end
			ST_FADE3: begin
				mul_a = 34'(t3_q);
				mul_b = 22'((prod_s1 >>> 16) + 10 * ONE);
			end
			ST_LERP0: begin
				mul_a = 34'(fd_q[lstep.axis]);
				mul_b = 22'(gr_q[lstep.ib]) - 22'(gr_q[lstep.ia]);
			end
			ST_ACC0: begin
				mul_a = 34'(amp_q);
				mul_b = 22'(gr_q[0]);
			end
			ST_ACC1: begin
				mul_a = 34'(amp_q);
				mul_b = 22'(pers_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		base = (k_q < 4'd2) ? '0 : IDX_W'(hreg_q[4'((k_q - 4'd2) >> 1)]);
		g = (k_q < 4'd2) ? gx_q : ((k_q < 4'd6) ? gy_q : gz_q);
		rd_addr = base + g + IDX_W'(k_q[0]);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (in_acc && req.func == FUNC_WRITE)
			mem[IDX_W'(req.entry_index)] <= req.entry_value;
		if (state_q == ST_RDA)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_q       <= 1'b0;
			oct_cfg_q   <= 4'd1;
			pers_q      <= 16'd16384;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					CFG_DIM:  dim_q <= cfg.data[0];
					CFG_OCT:  oct_cfg_q <= cfg.data[3:0];
					CFG_PERS: pers_q <= cfg.data;
					default:  ;
				endcase
			end
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] sx, sy, sz;
		logic signed [17:0] px, py, pz;
		sx = cx_q << oct_i_q;
		sy = cy_q << oct_i_q;
		sz = cz_q << oct_i_q;
		if (out_load)
			rsp_data_q <= sat_val;
		unique case (state_q)
			ST_IDLE: begin
				cx_q      <= req.coord_x;
				cy_q      <= req.coord_y;
				cz_q      <= req.coord_z;
				oct_i_q   <= '0;
				amp_q     <= AMP_W'(32768);
				amp_sum_q <= '0;
				total_q   <= '0;
			end
			ST_OCT: begin
				gx_q     <= IDX_W'(sx >> COORD_FRAC_BITS);
				gy_q     <= IDX_W'(sy >> COORD_FRAC_BITS);
				gz_q     <= IDX_W'(sz >> COORD_FRAC_BITS);
				fr_q[0]  <= 17'({1'b0, 16'(((sx & FRAC_MASK) >> DOWN_SH) << UP_SH)});
				fr_q[1]  <= 17'({1'b0, 16'(((sy & FRAC_MASK) >> DOWN_SH) << UP_SH)});
				fr_q[2]  <= 17'({1'b0, 16'(((sz & FRAC_MASK) >> DOWN_SH) << UP_SH)});
				ax_q     <= 2'd0;
				k_q      <= 4'd0;
				ls_q     <= 3'd0;
			end
			ST_FADE2: t3_q <= 18'(prod_s1 >>> 16);
			ST_FADE4: begin
				fd_q[ax_q] <= 18'(prod_s1 >>> 16);
				ax_q <= ax_q + 2'd1;
			end
			ST_RDD: begin
				hreg_q[k_q] <= rd_q;
				k_q <= k_q + 4'd1;
			end
			ST_GRAD: begin
				for (int c = 0; c < 8; c++) begin
					px = c[2] ? 18'(fr_q[0]) - 18'(ONE) : 18'(fr_q[0]);
					py = c[1] ? 18'(fr_q[1]) - 18'(ONE) : 18'(fr_q[1]);
					pz = c[0] ? 18'(fr_q[2]) - 18'(ONE) : 18'(fr_q[2]);
					if (dim_q)
						gr_q[c] <= slope3(hreg_q[6 + c], px, py, pz);
					else
						gr_q[c] <= slope2(hreg_q[2 + 2 * c[2] + c[1]], px, py);
				end
			end
			ST_LERP1: begin
				gr_q[lstep.ia] <= gr_q[lstep.ia] + 21'(prod_s1 >>> 16);
				ls_q <= (!dim_q && ls_q == 3'd1) ? 3'd4 : ls_q + 3'd1;
			end
			ST_ACC1: begin
				total_q   <= total_q + TOT_W'(prod_s1);
				amp_sum_q <= amp_sum_q + (AMP_W + 1)'(amp_q);
			end
			ST_ACC2: begin
				amp_q   <= AMP_W'(prod_s1 >>> 15);
				oct_i_q <= oct_i_q + CNT_W'(1);
				neg_q   <= total_q[TOT_W-1];
				quo_q   <= total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
				rem_q   <= '0;
				dvs_q   <= {amp_sum_q, 1'b0};
				dcnt_q  <= DC_W'(TOT_W);
			end
			ST_DIV: begin
				if (rem_sh >= (DW + 1)'(dvs_q)) begin
					rem_q <= DW'(rem_sh - (DW + 1)'(dvs_q));
					quo_q <= {quo_q[TOT_W-2:0], 1'b1};
				end else begin
					rem_q <= DW'(rem_sh);
					quo_q <= {quo_q[TOT_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - DC_W'(1);
			end
			default: ;
		endcase
	end

	`PON_ASSERT_NOW(a_take_idle, in_acc, state_q == ST_IDLE, "item taken while busy")
	`PON_ASSERT_NOW(a_oct_range, state_q == ST_OCT, oct_i_q < n_oct, "octave index out of range")
	`PON_ASSERT_NOW(a_rd_2d, state_q == ST_RDD && !dim_q, k_q < 4'd6, "2D read beyond hash set")
	`PON_ASSERT_NEXT(a_out_load, out_load, rsp_valid_q && state_q == ST_IDLE, "result not held")
endmodule

// ===== sim/perlin_octave_noise_test.sv =====
// Self-checking testbench for the octave noise engine: table loads, config sweeps, random noise.
`timescale 1ns / 1ps
module perlin_octave_noise_test;
	import pon_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	pon_in_if  req ();
	pon_out_if rsp ();
	pon_cfg_if cfg ();

	perlin_octave_noise dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always #6 clk = ~clk;

	logic [7:0]         perm_shadow [256];
	logic               dim_3d;
	logic [3:0]         octaves;
	logic [15:0]        persist;
	logic signed [15:0] noise_queue [$];
	int                 src_idle;
	int                 sink_idle;
	int                 fails;
	int                 idle_cycles = 0;
	int                 n_eval;
	int                 n_write;
	int                 n_cfg;

	function automatic longint fade_q16(longint t);
		longint inner, t2, t3;
		inner = ((t * (6 * t - 15 * 65536)) >>> 16) + 10 * 65536;
		t2 = (t * t) >>> 16;
		t3 = (t2 * t) >>> 16;
		return (t3 * inner) >>> 16;
	endfunction

	function automatic longint mix_q16(longint t, longint a, longint b);
		return a + ((t * (b - a)) >>> 16);
	endfunction

	function automatic int perm_at(int i);
		return perm_shadow[i[7:0]];
	endfunction

	function automatic longint grad2(int h, longint px, longint py);
		case (h & 7)
			0: return px + py;
			1: return px - py;
			2: return -px + py;
			3: return -px - py;
			4: return px;
			5: return -px;
			6: return py;
			default: return -py;
		endcase
	endfunction

	function automatic longint grad3(int h, longint px, longint py, longint pz);
		logic [3:0] k;
		longint s, r;
		k = h[3:0];
		s = (k < 8) ? px : py;
		r = (k < 4) ? py : ((k == 12 || k == 14) ? px : pz);
		return (k[0] ? -s : s) + (k[1] ? -r : r);
	endfunction

	function automatic longint frac_q16(logic [31:0] c);
		return longint'(c[23:8]);
	endfunction

	function automatic longint octave_2d(logic [31:0] cx, logic [31:0] cy);
		int gx, gy, h0, h1;
		longint fx, fy, u, v, r0, r1;
		gx = cx[31:24];
		gy = cy[31:24];
		fx = frac_q16(cx);
		fy = frac_q16(cy);
		u = fade_q16(fx);
		v = fade_q16(fy);
		h0 = perm_at(gx);
		h1 = perm_at(gx + 1);
		r0 = mix_q16(u, grad2(perm_at(h0 + gy), fx, fy),
			grad2(perm_at(h1 + gy), fx - 65536, fy));
		r1 = mix_q16(u, grad2(perm_at(h0 + gy + 1), fx, fy - 65536),
			grad2(perm_at(h1 + gy + 1), fx - 65536, fy - 65536));
		return mix_q16(v, r0, r1);
	endfunction

	function automatic longint octave_3d(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
		int gx, gy, gz, h0, h1, p00, p01, p10, p11;
		longint fx, fy, fz, mx, my, mz, u, v, w, a0, a1, a2, a3, b0, b1;
		gx = cx[31:24];
		gy = cy[31:24];
		gz = cz[31:24];
		fx = frac_q16(cx);
		fy = frac_q16(cy);
		fz = frac_q16(cz);
		u = fade_q16(fx);
		v = fade_q16(fy);
		w = fade_q16(fz);
		mx = fx - 65536;
		my = fy - 65536;
		mz = fz - 65536;
		h0 = perm_at(gx);
		h1 = perm_at(gx + 1);
		p00 = perm_at(h0 + gy);
		p01 = perm_at(h0 + gy + 1);
		p10 = perm_at(h1 + gy);
		p11 = perm_at(h1 + gy + 1);
		a0 = mix_q16(u, grad3(perm_at(p00 + gz), fx, fy, fz),
			grad3(perm_at(p10 + gz), mx, fy, fz));
		a1 = mix_q16(u, grad3(perm_at(p01 + gz), fx, my, fz),
			grad3(perm_at(p11 + gz), mx, my, fz));
		b0 = mix_q16(v, a0, a1);
		a2 = mix_q16(u, grad3(perm_at(p00 + gz + 1), fx, fy, mz),
			grad3(perm_at(p10 + gz + 1), mx, fy, mz));
		a3 = mix_q16(u, grad3(perm_at(p01 + gz + 1), fx, my, mz),
			grad3(perm_at(p11 + gz + 1), mx, my, mz));
		b1 = mix_q16(v, a2, a3);
		return mix_q16(w, b0, b1);
	endfunction

	function automatic logic signed [15:0] fractal_noise(logic [31:0] x, logic [31:0] y,
		logic [31:0] z);
		int n;
		longint amp, amp_sum, total, val, q;
		logic [31:0] sx, sy, sz;
		n = (octaves == 0) ? 1 : ((octaves > 8) ? 8 : octaves);
		amp = 32768;
		amp_sum = 0;
		total = 0;
		for (int i = 0; i < n; i++) begin
			sx = x << i;
			sy = y << i;
			sz = z << i;
			val = dim_3d ? octave_3d(sx, sy, sz) : octave_2d(sx, sy);
			total += val * amp;
			amp_sum += amp;
			amp = (amp * longint'(persist)) >> 15;
		end
		q = total / (amp_sum * 2);
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	task automatic send_item(logic func, logic [7:0] idx, logic [7:0] val,
		logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle);
		end
		req.valid       <= 1'b1;
		req.func        <= func;
		req.entry_index <= idx;
		req.entry_value <= val;
		req.coord_x     <= x;
		req.coord_y     <= y;
		req.coord_z     <= z;
		do
			@(posedge clk);
		while (!req.ready);
		if (func == FUNC_EVAL) begin
			noise_queue.push_back(fractal_noise(x, y, z));
			n_eval++;
		end else begin
			perm_shadow[idx] = val;
			n_write++;
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (noise_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		n_cfg++;
		case (idx)
			CFG_DIM:  dim_3d = data[0];
			CFG_OCT:  octaves = data[3:0];
			CFG_PERS: persist = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic d, logic [3:0] o, logic [15:0] p);
		write_reg(CFG_DIM, {15'd0, d});
		write_reg(CFG_OCT, {12'd0, o});
		write_reg(CFG_PERS, p);
	endtask

	task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_item(FUNC_EVAL, 8'($urandom), 8'($urandom), x, y, z);
	endtask

	task automatic test_table_load();
		for (int i = 0; i < 256; i++)
			send_item(FUNC_WRITE, i[7:0], 8'($urandom), $urandom, $urandom, $urandom);
		send_item(FUNC_WRITE, 8'd0, 8'd255, 32'd0, 32'd0, 32'd0);
		send_item(FUNC_WRITE, 8'd255, 8'd0, '1, '1, '1);
	endtask

	task automatic test_directed_eval();
		eval_at(32'd0, 32'd0, 32'd0);
		eval_at('1, '1, '1);
		eval_at(32'h0100_0000, 32'hFF00_0000, 32'h8000_0000);
		eval_at(32'h00FF_FFFF, 32'h0080_0000, 32'h0000_00FF);
		set_config(1'b1, 4'd1, 16'd16384);
		eval_at(32'd0, 32'd0, 32'd0);
		eval_at('1, '1, '1);
		eval_at(32'h7F80_0000, 32'h0140_0000, 32'hFFFF_0000);
		set_config(1'b0, 4'd0, 16'd0);
		eval_at(32'h1234_5678, 32'h9ABC_DEF0, 32'd0);
		set_config(1'b1, 4'd15, 16'hFFFF);
		eval_at(32'hDEAD_BEEF, 32'h8000_0001, 32'h0F0F_F0F0);
		eval_at('1, '1, '1);
		set_config(1'b0, 4'd8, 16'hFFFF);
		eval_at(32'hA5A5_5A5A, 32'hFFFF_FFFE, 32'd1);
		write_reg(CFG_UNUSED, 16'hFFFF);
		eval_at(32'h0001_0000, 32'h00FF_0000, 32'd0);
		write_reg(CFG_OCT, 16'hFFF9);
		eval_at(32'h4000_4000, 32'hC000_C000, 32'd0);
	endtask

	task automatic test_random(int items);
		logic [3:0] o;
		logic [15:0] p;
		for (int s = 0; s < 4; s++) begin
			o = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
			case ($urandom_range(3))
				0: p = 16'd0;
				1: p = 16'hFFFF;
				default: p = 16'($urandom);
			endcase
			set_config(1'($urandom_range(1)), o, p);
			for (int i = 0; i < items / 4; i++) begin
				if ($urandom_range(9) < 3)
					send_item(FUNC_WRITE, 8'($urandom), 8'($urandom), $urandom, $urandom,
						$urandom);
				else
					eval_at($urandom, $urandom, $urandom);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (noise_queue.size() == 0) begin
				$error("noise_value: no result expected, actual %0d", rsp.noise_value);
				fails++;
			end else begin
				if (rsp.noise_value !== noise_queue[0]) begin
					$error("noise_value: expected %0d, actual %0d", noise_queue[0],
						rsp.noise_value);
					fails++;
				end
				void'(noise_queue.pop_front());
			end
		end
		rsp.ready <= arst_n && ($urandom_range(99) >= sink_idle);
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.func        <= FUNC_WRITE;
		req.entry_index <= '0;
		req.entry_value <= '0;
		req.coord_x     <= '0;
		req.coord_y     <= '0;
		req.coord_z     <= '0;
		cfg.valid       <= 1'b0;
		cfg.index       <= CFG_DIM;
		cfg.data        <= '0;
		dim_3d    = 1'b0;
		octaves   = 4'd1;
		persist   = 16'd16384;
		fails     = 0;
		n_eval    = 0;
		n_write   = 0;
		n_cfg     = 0;
		src_idle  = 0;
		sink_idle = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_directed_eval();
		src_idle  = 6;
		sink_idle = 51;
		test_random(112);
		src_idle  = 51;
		sink_idle = 6;
		test_random(112);
		src_idle  = 0;
		sink_idle = 0;
		test_random(112);
		drain();
		$display("Covered %0d evaluations and %0d table writes over %0d register writes,",
			n_eval, n_write, n_cfg);
		$display("2D and 3D modes, octave counts 0 to 15, persistence extremes, three idle mixes.");
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/pon_pkg.sv
hdl/pon_if.sv
hdl/perlin_octave_noise.sv
sim/perlin_octave_noise_test.sv
